### hdl/qopt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qopt_pkg
// shared constants for the odometry pose tracker
// ----------------------------------------------------------------------------
package qopt_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int ATAN_DEPTH       = 24;

    localparam logic [31:0] GAIN_INV = 32'd652032874;

    localparam logic [2:0] REG_RIGHT_CM = 3'd0;
    localparam logic [2:0] REG_LEFT_CM  = 3'd1;
    localparam logic [2:0] REG_RA_FWD   = 3'd2;
    localparam logic [2:0] REG_RA_REV   = 3'd3;
    localparam logic [2:0] REG_LA_FWD   = 3'd4;
    localparam logic [2:0] REG_LA_REV   = 3'd5;

    localparam logic [1:0] KIND_RIGHT = 2'd0;
    localparam logic [1:0] KIND_LEFT  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;
    localparam logic [1:0] KIND_SET   = 2'd3;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### hdl/quadrature_odometry_pose_tracker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_odometry_pose_tracker_core
// encoder counting and dead reckoning with a bit-serial cordic and multiplier
// ----------------------------------------------------------------------------
// edge and set-pose words are taken in the idle state; a tick word holds the input
// through the four shift-add products, the bit-serial cordic adders and the two scale
// products, plus any wait on a held result
// one word at a time; the result sits in an output register that frees the input
// reset clears counts and pose and sets the calibration registers to their default values
module quadrature_odometry_pose_tracker_core #(
    parameter int CORDIC_STEPS = qopt_pkg::CORDIC_STEPS_DEF,
    parameter int COUNT_WIDTH  = qopt_pkg::COUNT_WIDTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [87:0] s_tdata,   // chan_a, chan_b, new_x, new_y, new_heading, pad
    input  wire  [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [111:0] m_tdata,  // pos_x, pos_y, heading_out, right_step, left_step
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [23:0] cfg_data
);
    localparam int NSTEP = (CORDIC_STEPS > qopt_pkg::ATAN_DEPTH) ?
                           qopt_pkg::ATAN_DEPTH : CORDIC_STEPS;
    localparam int W  = 34;   // serial word for the cordic adders
    localparam logic signed [COUNT_WIDTH-1:0] LIM = {1'b0, {(COUNT_WIDTH-1){1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DZ, S_ROT, S_ITER, S_SCX, S_SCY, S_DONE
    } state_t;

    state_t state_reg;
    logic [15:0] rcm_reg, lcm_reg;
    logic [23:0] raf_reg, rar_reg, laf_reg, lar_reg;
    logic signed [COUNT_WIDTH-1:0] racc_reg, lacc_reg, r_reg, l_reg;
    logic [31:0] x_reg, y_reg, th_reg;

    // bit-serial multiply: acc += mcand when multiplier bit set, multiplier shifts
    logic [1:0]  mi_reg;          // which product
    logic [6:0]  cnt_reg;
    logic signed [63:0] mc_reg;   // multiplicand (shifted left)
    logic [63:0] mp_reg;          // multiplier magnitude bits
    logic        mneg_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg;
    logic signed [63:0] dist_reg;

    // cordic, serial add of 34-bit values
    logic signed [W-1:0] cx_reg, cy_reg, cz_reg, xs_reg, ys_reg;
    logic [4:0]  it_reg;
    logic        flip_reg, dir_reg, carx_reg, cary_reg, carz_reg;
    logic [31:0] at_reg;
    logic [5:0]  bit_reg;

    logic [111:0] out_reg;
    logic        ov_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ov_reg;
    assign m_tdata   = out_reg;

    logic [1:0] kind;
    logic ca, cb;
    assign kind = s_tuser;
    assign ca   = s_tdata[0];
    assign cb   = s_tdata[1];

    function automatic logic signed [COUNT_WIDTH-1:0] cstep(
        input logic signed [COUNT_WIDTH-1:0] a, input logic up);
        logic signed [COUNT_WIDTH-1:0] r;
        r = a;
        if (up && a < LIM) r = a + 1'b1;
        else if (!up && a > -LIM) r = a - 1'b1;
        return r;
    endfunction

    // start values for each product
    logic signed [63:0] mcs;
    logic [63:0] mps;
    logic        mns;
    always_comb
    begin
        mcs = '0; mps = '0; mns = 1'b0;
        case (mi_reg)
            2'd0:
            begin
                mcs = 64'(r_reg);
                mps = {48'd0, rcm_reg};
            end
            2'd1:
            begin
                mcs = 64'(l_reg);
                mps = {48'd0, lcm_reg};
            end
            2'd2:
            begin
                mcs = 64'(r_reg);
                mps = {40'd0, (r_reg > 0) ? raf_reg : rar_reg};
            end
            default:
            begin
                mcs = 64'(l_reg);
                mps = {40'd0, (l_reg > 0) ? laf_reg : lar_reg};
            end
        endcase
    end

    // serial adder bits
    logic sx, sy, sz, bx, by, bz, opx, opy, opz;
    logic signed [63:0] dz_w, mid_w;
    always_comb
    begin
        opx = dir_reg ? ~ys_reg[0] : ys_reg[0];
        opy = dir_reg ? xs_reg[0] : ~xs_reg[0];
        opz = dir_reg ? ~at_reg[0] : at_reg[0];
        {bx, sx} = {1'b0, cx_reg[0]} + {1'b0, opx} + {1'b0, carx_reg};
        {by, sy} = {1'b0, cy_reg[0]} + {1'b0, opy} + {1'b0, cary_reg};
        {bz, sz} = {1'b0, cz_reg[0]} + {1'b0, opz} + {1'b0, carz_reg};
        dz_w  = (p2_reg - p1_reg) >>> 1;
        mid_w = dz_w >>> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rcm_reg <= 16'd1115; lcm_reg <= 16'd1109;
            raf_reg <= 24'd775017; rar_reg <= 24'd775017;
            laf_reg <= 24'd770649; lar_reg <= 24'd771518;
            racc_reg <= '0; lacc_reg <= '0;
            x_reg <= '0; y_reg <= '0; th_reg <= '0;
            ov_reg <= 1'b0;
            mi_reg <= '0; cnt_reg <= '0; it_reg <= '0; bit_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    qopt_pkg::REG_RIGHT_CM: rcm_reg <= cfg_data[15:0];
                    qopt_pkg::REG_LEFT_CM:  lcm_reg <= cfg_data[15:0];
                    qopt_pkg::REG_RA_FWD:   raf_reg <= cfg_data;
                    qopt_pkg::REG_RA_REV:   rar_reg <= cfg_data;
                    qopt_pkg::REG_LA_FWD:   laf_reg <= cfg_data;
                    qopt_pkg::REG_LA_REV:   lar_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ov_reg && m_tready) ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        unique case (kind)
                            qopt_pkg::KIND_RIGHT: racc_reg <= cstep(racc_reg, ca != cb);
                            qopt_pkg::KIND_LEFT:  lacc_reg <= cstep(lacc_reg, ca == cb);
                            qopt_pkg::KIND_SET:
                            begin
                                x_reg <= s_tdata[33:2];
                                y_reg <= s_tdata[65:34];
                                th_reg <= {s_tdata[81:66], 16'd0};
                                racc_reg <= '0; lacc_reg <= '0;
                            end
                            default:
                            begin
                                r_reg <= racc_reg; l_reg <= lacc_reg;
                                racc_reg <= '0; lacc_reg <= '0;
                                mi_reg <= 2'd0; cnt_reg <= '0;
                                acc_reg <= '0;
                                state_reg <= S_MUL;
                            end
                        endcase
                    end
                end
                S_MUL:
                begin
                    if (cnt_reg == 7'd0)
                    begin
                        mc_reg <= mcs; mp_reg <= mps; mneg_reg <= mns;
                        acc_reg <= '0;
                        cnt_reg <= 7'd1;
                    end
                    else if (cnt_reg <= 7'd24)
                    begin
                        if (mp_reg[0]) acc_reg <= acc_reg + mc_reg;
                        mc_reg <= mc_reg <<< 1;
                        mp_reg <= mp_reg >> 1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= '0;
                        unique case (mi_reg)
                            2'd0: p0_reg <= acc_reg;
                            2'd1:
                            begin
                                p1_reg <= acc_reg;
                                dist_reg <= (p0_reg + acc_reg) >>> 1;
                            end
                            2'd2: p2_reg <= acc_reg;
                            default:
                            begin
                                p1_reg <= acc_reg;
                                state_reg <= S_DZ;
                            end
                        endcase
                        mi_reg <= mi_reg + 1'b1;
                    end
                end
                S_DZ:
                begin
                    // dz in p2, mid angle into cz
                    p2_reg <= dz_w;
                    begin
                        logic [31:0] m;
                        m = th_reg + mid_w[31:0];
                        if (!m[31] && m > 32'h40000000)
                        begin
                            cz_reg <= W'($signed({1'b0, m}) - 33'sh080000000);
                            flip_reg <= 1'b1;
                        end
                        else if (m[31] && m < 32'hC0000000)
                        begin
                            cz_reg <= W'($signed({1'b1, m}) + 33'sh080000000);
                            flip_reg <= 1'b1;
                        end
                        else
                        begin
                            cz_reg <= W'($signed(m));
                            flip_reg <= 1'b0;
                        end
                    end
                    cx_reg <= W'(qopt_pkg::GAIN_INV);
                    cy_reg <= '0;
                    it_reg <= '0;
                    state_reg <= (NSTEP == 0) ? S_SCX : S_ROT;
                end
                S_ROT:
                begin
                    xs_reg <= cx_reg >>> it_reg;
                    ys_reg <= cy_reg >>> it_reg;
                    at_reg <= qopt_pkg::atan_lut(it_reg);
                    dir_reg <= !cz_reg[W-1];
                    carx_reg <= !cz_reg[W-1];
                    cary_reg <= cz_reg[W-1];
                    carz_reg <= !cz_reg[W-1];
                    bit_reg <= '0;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    cx_reg <= {sx, cx_reg[W-1:1]};
                    cy_reg <= {sy, cy_reg[W-1:1]};
                    cz_reg <= {sz, cz_reg[W-1:1]};
                    xs_reg <= {xs_reg[W-1], xs_reg[W-1:1]};
                    ys_reg <= {ys_reg[W-1], ys_reg[W-1:1]};
                    at_reg <= {1'b0, at_reg[31:1]};
                    carx_reg <= bx; cary_reg <= by; carz_reg <= bz;
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == 6'(W-1))
                    begin
                        if (it_reg == 5'(NSTEP-1))
                        begin
                            cnt_reg <= '0;
                            state_reg <= S_SCX;
                        end
                        else
                        begin
                            it_reg <= it_reg + 1'b1;
                            state_reg <= S_ROT;
                        end
                    end
                end
                S_SCX, S_SCY:
                begin
                    if (cnt_reg == 7'd0)
                    begin
                        logic signed [W-1:0] k;
                        k = (state_reg == S_SCX) ? cx_reg : cy_reg;
                        if (flip_reg) k = -k;
                        mc_reg <= dist_reg;
                        mp_reg <= 64'(k < 0 ? -k : k);
                        mneg_reg <= k < 0;
                        acc_reg <= '0;
                        cnt_reg <= 7'd1;
                    end
                    else if (cnt_reg <= 7'd32)
                    begin
                        if (mp_reg[0]) acc_reg <= acc_reg + mc_reg;
                        mc_reg <= mc_reg <<< 1;
                        mp_reg <= mp_reg >> 1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        logic signed [63:0] q;
                        q = (mneg_reg ? -acc_reg : acc_reg) >>> 30;
                        cnt_reg <= '0;
                        if (state_reg == S_SCX)
                        begin
                            x_reg <= x_reg + q[31:0];
                            state_reg <= S_SCY;
                        end
                        else
                        begin
                            y_reg <= y_reg + q[31:0];
                            th_reg <= th_reg + p2_reg[31:0];
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!ov_reg)
                    begin
                        out_reg <= {16'(l_reg), 16'(r_reg), th_reg[31:16], y_reg, x_reg};
                        ov_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == S_IDLE)) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (racc_reg >= -LIM) && (lacc_reg >= -LIM)) else $error("count past limit");

endmodule
`default_nettype wire
